/* rtl/ptq_pkg.sv */
// Shared types and codes of the periodic timer queue.
// No dependencies; every other file in rtl but ptq_fifo imports this package.
package ptq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [2:0] KIND_INSERTED = 3'd0;
	localparam logic [2:0] KIND_REPLACED = 3'd1;
	localparam logic [2:0] KIND_FULL     = 3'd2;
	localparam logic [2:0] KIND_REMOVED  = 3'd3;
	localparam logic [2:0] KIND_NOTFOUND = 3'd4;
	localparam logic [2:0] KIND_FIRED    = 3'd5;
	localparam logic [2:0] KIND_NONE     = 3'd6;

	typedef enum logic [1:0] {OP_INSERT, OP_REMOVE, OP_TICK} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  client;
		logic [31:0] code;
		logic [31:0] due;
		logic [31:0] period;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [7:0]  client;
		logic [31:0] code;
		logic [31:0] due;
		logic [31:0] period;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  client;
		logic [31:0] code;
		logic        last;
	} res_t;

endpackage

/* rtl/periodic_timer_queue_top.sv */
// Periodic timer queue: insert, remove and tick requests over a DEPTH-slot timer table.
// Insert/remove: the slot scan sets the time from push to result.
// Tick: one scan per firing, plus a final scan or the flush state.
// One request at a time in the engine; QUEUE_DEPTH wait.
// Reset (arst_n low) empties both queues and marks every timer slot free at once.
// Depends on ptq_pkg, ptq_fifo, ptq_front and ptq_engine.
module periodic_timer_queue_top #(
	parameter int DEPTH  = ptq_pkg::DEPTH_DEF,
	parameter int QDEPTH = ptq_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  client_id,
	input  logic [31:0] event_code,
	input  logic [31:0] first_due,
	input  logic [31:0] reload_period,
	input  logic [31:0] now_time,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  result_kind,
	output logic [7:0]  fired_client,
	output logic [31:0] fired_code,
	output logic        last_result
);
	import ptq_pkg::*;

	req_t req_item;
	logic req_empty, req_pop;
	res_t res_data, res_out;
	logic res_push, res_full;

	// Front: decode and queue each transfer; unknown request types are dropped.
	ptq_front #(.QDEPTH(QDEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.client_id    (client_id),
		.event_code   (event_code),
		.first_due    (first_due),
		.reload_period(reload_period),
		.now_time     (now_time),
		.req_pop      (req_pop),
		.req_item     (req_item),
		.req_empty    (req_empty)
	);

	// Back: scan the table, apply the request, emit results in order.
	ptq_engine #(.DEPTH(DEPTH)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.req_empty(req_empty),
		.req_pop  (req_pop),
		.res_push (res_push),
		.res_data (res_data),
		.res_full (res_full)
	);

	// Result queue: hold finished results so the engine keeps going while pop is low, until the queue fills.
	ptq_fifo #(.item_t(res_t), .DEPTH_F(QDEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_data),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign result_kind  = res_out.kind;
	assign fired_client = res_out.client;
	assign fired_code   = res_out.code;
	assign last_result  = res_out.last;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result queue overflow");

	a_req_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> !req_empty) else $error("request queue underflow");

	a_nonfired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.kind != KIND_FIRED) |->
		(res_data.client == '0 && res_data.code == '0 && res_data.last))
		else $error("non-fired result carries payload");
endmodule

/* rtl/ptq_fifo.sv */
// Small synchronous FIFO of a generic payload type.
// Depends on nothing but its parameters.
module ptq_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH_F = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	output logic  full,
	input  logic  rd,
	output item_t rdata,
	output logic  empty
);
	localparam int AW = (DEPTH_F > 1) ? $clog2(DEPTH_F) : 1;

	item_t         mem_q [DEPTH_F];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH_F));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH_F-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH_F-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

/* rtl/ptq_front.sv */
// Front end: accepts requests, decodes the request type, queues them.
// Depends on ptq_pkg and ptq_fifo.
module ptq_front #(
	parameter int QDEPTH = ptq_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    req_type,
	input  logic [7:0]    client_id,
	input  logic [31:0]   event_code,
	input  logic [31:0]   first_due,
	input  logic [31:0]   reload_period,
	input  logic [31:0]   now_time,
	input  logic          req_pop,
	output ptq_pkg::req_t req_item,
	output logic          req_empty
);
	import ptq_pkg::*;

	req_t item;
	logic legal;

	always_comb begin
		legal   = 1'b1;
		item.op = OP_TICK;
		unique case (req_type)
			REQ_INSERT: item.op = OP_INSERT;
			REQ_REMOVE: item.op = OP_REMOVE;
			REQ_TICK:   item.op = OP_TICK;
			default:    legal   = 1'b0;  // unused type: drop
		endcase
		item.client = client_id;
		item.code   = event_code;
		item.due    = first_due;
		item.period = reload_period;
		item.now    = now_time;
	end

	ptq_fifo #(.item_t(req_t), .DEPTH_F(QDEPTH)) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push && legal),
		.wdata (item),
		.full  (full),
		.rd    (req_pop),
		.rdata (req_item),
		.empty (req_empty)
	);
endmodule

/* rtl/ptq_engine.sv */
// Back end: timer table with a sequential slot scan per request, and per firing for a tick.
// Depends on ptq_pkg.
module ptq_engine #(
	parameter int DEPTH = ptq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ptq_pkg::req_t req_item,
	input  logic          req_empty,
	output logic          req_pop,
	output logic          res_push,
	output ptq_pkg::res_t res_data,
	input  logic          res_full
);
	import ptq_pkg::*;

	localparam int IW = $clog2(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT, S_FLUSH} state_t;

	state_t        state_q;
	req_t          cur_q;
	logic          valid_q [DEPTH];
	entry_t        mem_q [DEPTH];
	logic [IW:0]   scan_q;
	entry_t        rd_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic          found_q, free_found_q;
	logic [IW-1:0] best_idx_q, free_idx_q;
	entry_t        best_q;
	logic          pend_q;
	logic [7:0]    pend_client_q;
	logic [31:0]   pend_code_q;
	logic [IW:0]   fire_cnt_q;

	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;
	logic          act_go;
	logic          rd_hit;

	assign rd_hit = valid_q[rd_idx_s1];

	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		mem_we   = 1'b0;
		mem_wa   = best_idx_q;
		mem_wd   = '{client: cur_q.client, code: cur_q.code,
			due: cur_q.due, period: cur_q.period};
		req_pop  = (state_q == S_IDLE) && !req_empty;
		res_data.last = 1'b1;
		if (state_q == S_ACT) begin
			unique case (cur_q.op)
				OP_INSERT: begin
					res_push = 1'b1;
					if (found_q) begin
						res_data.kind = KIND_REPLACED;
						mem_we = 1'b1;
					end else if (free_found_q) begin
						res_data.kind = KIND_INSERTED;
						mem_we = 1'b1;
						mem_wa = free_idx_q;
					end else begin
						res_data.kind = KIND_FULL;
					end
				end
				OP_REMOVE: begin
					res_push = 1'b1;
					res_data.kind = found_q ? KIND_REMOVED : KIND_NOTFOUND;
				end
				OP_TICK: begin
					if (found_q) begin
						// Hand out the previous firing; another one follows.
						res_push = pend_q;
						res_data = '{kind: KIND_FIRED, client: pend_client_q,
							code: pend_code_q, last: 1'b0};
						mem_we = (best_q.period != '0);
						mem_wd = best_q;
						mem_wd.due = best_q.due + best_q.period;
					end else begin
						res_push = 1'b1;
						if (pend_q) begin
							res_data = '{kind: KIND_FIRED, client: pend_client_q,
								code: pend_code_q, last: 1'b1};
						end else begin
							res_data.kind = KIND_NONE;
						end
					end
				end
				default: ;
			endcase
		end else if (state_q == S_FLUSH) begin
			res_push = 1'b1;
			res_data = '{kind: KIND_FIRED, client: pend_client_q,
				code: pend_code_q, last: 1'b1};
		end
		act_go = !res_push || !res_full;
		if (!act_go || state_q != S_ACT) begin
			mem_we = 1'b0;
		end
		if (!act_go) begin
			res_push = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (scan_q < (IW+1)'(DEPTH)) begin
			rd_s1     <= mem_q[scan_q[IW-1:0]];
			rd_idx_s1 <= scan_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			scan_q       <= (IW+1)'(DEPTH);
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			best_idx_q   <= '0;
			free_idx_q   <= '0;
			best_q       <= '0;
			pend_q       <= 1'b0;
			pend_client_q <= '0;
			pend_code_q  <= '0;
			fire_cnt_q   <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!req_empty) begin
						cur_q        <= req_item;
						state_q      <= S_SCAN;
						scan_q       <= '0;
						rd_vld_s1    <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= (scan_q < (IW+1)'(DEPTH));
					if (scan_q < (IW+1)'(DEPTH)) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (cur_q.op == OP_TICK) begin
							if (rd_hit && rd_s1.due <= cur_q.now &&
								(!found_q || rd_s1.due < best_q.due)) begin
								found_q    <= 1'b1;
								best_idx_q <= rd_idx_s1;
								best_q     <= rd_s1;
							end
						end else begin
							if (rd_hit && !found_q && rd_s1.client == cur_q.client &&
								rd_s1.code == cur_q.code) begin
								found_q    <= 1'b1;
								best_idx_q <= rd_idx_s1;
							end
							if (!rd_hit && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= rd_idx_s1;
							end
						end
						if (rd_idx_s1 == IW'(DEPTH-1)) begin
							state_q   <= S_ACT;
							rd_vld_s1 <= 1'b0;
						end
					end
				end
				S_ACT: begin
					if (act_go) begin
						unique case (cur_q.op)
							OP_INSERT: begin
								if (found_q) begin
									valid_q[best_idx_q] <= 1'b1;
								end else if (free_found_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end
								state_q <= S_IDLE;
							end
							OP_REMOVE: begin
								if (found_q) begin
									valid_q[best_idx_q] <= 1'b0;
								end
								state_q <= S_IDLE;
							end
							OP_TICK: begin
								if (found_q) begin
									pend_q        <= 1'b1;
									pend_client_q <= best_q.client;
									pend_code_q   <= best_q.code;
									if (best_q.period == '0) begin
										valid_q[best_idx_q] <= 1'b0;
									end
									fire_cnt_q <= fire_cnt_q + 1'b1;
									if (fire_cnt_q == (IW+1)'(DEPTH-1)) begin
										state_q <= S_FLUSH;
									end else begin
										state_q      <= S_SCAN;
										scan_q       <= '0;
										found_q      <= 1'b0;
									end
								end else begin
									pend_q     <= 1'b0;
									fire_cnt_q <= '0;
									state_q    <= S_IDLE;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FLUSH: begin
					if (act_go) begin
						pend_q     <= 1'b0;
						fire_cnt_q <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
